/* rtl/tmcw_pkg.sv */
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants for the text-mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int COPY_CELLS  = CELLS - COLUMNS;

  localparam int IDX_W       = 11;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int CNT_W       = $clog2(CELLS + 1);

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_CYCLE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'h86;
  localparam logic [4:0] CYCLE_WRAP   = 5'd15;
  localparam logic [3:0] CYCLE_FIRST  = 4'd1;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [7:0]       color;
    logic [IDX_W-1:0] pos;
    logic             newline;
    logic             scroll;
    logic [ROW_W-1:0] row_nxt;
    logic [COL_W-1:0] col_nxt;
  } cur_info_t;

endpackage

/* rtl/tmcw_cell_ram.sv */
// ----------------------------------------------------------------------------
// tmcw_cell_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tmcw_cell_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [tmcw_pkg::IDX_W-1:0] waddr,
  input  logic [15:0]               wdata,
  input  logic                      re,
  input  logic [tmcw_pkg::IDX_W-1:0] raddr,
  output logic [15:0]               rdata
);

  logic [15:0] mem [tmcw_pkg::CELLS];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/tmcw_cursor.sv */
// ----------------------------------------------------------------------------
// tmcw_cursor
// Cursor position, current colour and colour-cycle step, with next-position
// and scroll decode for a write transfer.
// ----------------------------------------------------------------------------
module tmcw_cursor (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  cycle,
  input  logic [7:0]            char_code,
  input  logic                  end_of_string,
  output tmcw_pkg::cur_info_t   info
);

  logic [tmcw_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [tmcw_pkg::COL_W-1:0] col_r, col_nxt;
  logic [7:0]                 color_r, color_nxt;
  logic [3:0]                 cstep_r, cstep_nxt;
  logic [tmcw_pkg::COL_W:0]   col_inc;
  logic [4:0]                 cstep_inc;
  logic                       newline;
  logic                       wrap;
  logic                       last_row;

  assign newline   = (char_code == tmcw_pkg::NEWLINE_CODE);
  assign col_inc   = {1'b0, col_r} + 1'b1;
  assign wrap      = newline || (col_inc == (tmcw_pkg::COL_W+1)'(tmcw_pkg::COLUMNS));
  assign last_row  = (row_r == tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1));
  assign cstep_inc = {1'b0, cstep_r} + 5'd1;

  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    color_nxt = color_r;
    cstep_nxt = cstep_r;
    if (wrap) begin
      col_nxt = '0;
      if (!last_row) begin
        row_nxt = row_r + 1'b1;
      end
    end else begin
      col_nxt = col_inc[tmcw_pkg::COL_W-1:0];
    end
    if (cycle) begin
      color_nxt = {cstep_r - 4'd1, cstep_r};
      if (end_of_string || cstep_inc >= tmcw_pkg::CYCLE_WRAP) begin
        cstep_nxt = tmcw_pkg::CYCLE_FIRST;
      end else begin
        cstep_nxt = cstep_inc[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      color_r <= tmcw_pkg::RESET_COLOR;
      cstep_r <= tmcw_pkg::CYCLE_FIRST;
    end else if (step) begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      color_r <= color_nxt;
      cstep_r <= cstep_nxt;
    end
  end

  always_comb begin
    info.row     = row_r;
    info.col     = col_r;
    info.color   = color_r;
    info.pos     = tmcw_pkg::IDX_W'(row_r) * tmcw_pkg::IDX_W'(tmcw_pkg::COLUMNS)
                   + tmcw_pkg::IDX_W'(col_r);
    info.newline = newline;
    info.scroll  = wrap && last_row;
    info.row_nxt = row_nxt;
    info.col_nxt = col_nxt;
  end

endmodule

/* rtl/text_mode_console_writer.sv */
// ----------------------------------------------------------------------------
// text_mode_console_writer
// Character console over an 80x25 store of 16-bit text cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | req_type, char_code, cell_index,
//          |           |                      | end_of_string
//  out_    | output    | out_valid / out_ready| cell_index_res, cell_value,
//          |           |                      | scrolled, cursor_row, cursor_column
//
//  Character or newline without scroll: result registered at transfer.
//  Read: data passes the registered read port of the cell store, then the result register.
//  Scroll: one cell moved per cycle through the store.
//  After reset a clearing pass fills the store; no input transfer is taken
//  during it. A stalled result blocks the next input only until it is taken.
// ----------------------------------------------------------------------------
module text_mode_console_writer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_req_type,
  input  logic [7:0]                   in_char_code,
  input  logic [10:0]                  in_cell_index,
  input  logic                         in_end_of_string,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [10:0]                  out_cell_index_res,
  output logic [15:0]                  out_cell_value,
  output logic                         out_scrolled,
  output logic [4:0]                   out_cursor_row,
  output logic [6:0]                   out_cursor_column
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_READ   = 4'b0100,
    ST_SCROLL = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [tmcw_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]                  blank_r, blank_nxt;
  logic                        oob_r, oob_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [10:0]                 res_idx_r, res_idx_nxt;
  logic [15:0]                 res_val_r, res_val_nxt;
  logic                        res_scr_r, res_scr_nxt;
  logic [4:0]                  res_row_r, res_row_nxt;
  logic [6:0]                  res_col_r, res_col_nxt;

  tmcw_pkg::cur_info_t         info;
  logic                        acc;
  logic                        is_read;
  logic                        wr_acc;
  logic                        mem_we;
  logic [tmcw_pkg::IDX_W-1:0]  mem_waddr;
  logic [15:0]                 mem_wdata;
  logic                        mem_re;
  logic [tmcw_pkg::IDX_W-1:0]  mem_raddr;
  logic [15:0]                 mem_rdata;
  logic [tmcw_pkg::CNT_W-1:0]  cnt_dec;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;
  assign is_read  = (in_req_type != tmcw_pkg::REQ_WRITE) &&
                    (in_req_type != tmcw_pkg::REQ_CYCLE);
  assign wr_acc   = acc && !is_read;
  assign cnt_dec  = cnt_r - 1'b1;

  tmcw_cursor u_cursor (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (wr_acc),
    .cycle         (in_req_type == tmcw_pkg::REQ_CYCLE),
    .char_code     (in_char_code),
    .end_of_string (in_end_of_string),
    .info          (info)
  );

  tmcw_cell_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = info.pos;
    mem_wdata = {info.color, in_char_code};
    mem_re    = 1'b0;
    mem_raddr = in_cell_index;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[tmcw_pkg::IDX_W-1:0];
        mem_wdata = {tmcw_pkg::RESET_COLOR, tmcw_pkg::SPACE_CODE};
      end
      ST_IDLE: begin
        mem_we = wr_acc && !info.newline;
        mem_re = acc && is_read &&
                 (in_cell_index < tmcw_pkg::IDX_W'(tmcw_pkg::CELLS));
      end
      ST_SCROLL: begin
        mem_we    = (cnt_r != '0);
        mem_waddr = cnt_dec[tmcw_pkg::IDX_W-1:0];
        mem_wdata = (cnt_r <= tmcw_pkg::CNT_W'(tmcw_pkg::COPY_CELLS)) ?
                    mem_rdata : {blank_r, tmcw_pkg::SPACE_CODE};
        mem_re    = (cnt_r < tmcw_pkg::CNT_W'(tmcw_pkg::COPY_CELLS));
        mem_raddr = cnt_r[tmcw_pkg::IDX_W-1:0] +
                    tmcw_pkg::IDX_W'(tmcw_pkg::COLUMNS);
      end
      default: begin
        mem_we = 1'b0;
        mem_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    blank_nxt     = blank_r;
    oob_nxt       = oob_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_idx_nxt   = res_idx_r;
    res_val_nxt   = res_val_r;
    res_scr_nxt   = res_scr_r;
    res_row_nxt   = res_row_r;
    res_col_nxt   = res_col_r;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tmcw_pkg::CNT_W'(tmcw_pkg::CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc && is_read) begin
          res_idx_nxt = in_cell_index;
          res_scr_nxt = 1'b0;
          res_row_nxt = info.row;
          res_col_nxt = info.col;
          oob_nxt     = (in_cell_index >= tmcw_pkg::IDX_W'(tmcw_pkg::CELLS));
          state_nxt   = ST_READ;
        end else if (wr_acc) begin
          res_idx_nxt = info.newline ? '0 : info.pos;
          res_val_nxt = info.newline ? '0 : {info.color, in_char_code};
          res_scr_nxt = info.scroll;
          res_row_nxt = info.row_nxt;
          res_col_nxt = info.col_nxt;
          blank_nxt   = info.color;
          if (info.scroll) begin
            cnt_nxt   = '0;
            state_nxt = ST_SCROLL;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        res_val_nxt   = oob_r ? '0 : mem_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SCROLL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tmcw_pkg::CNT_W'(tmcw_pkg::CELLS)) begin
          cnt_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blank_r   <= blank_nxt;
    oob_r     <= oob_nxt;
    res_idx_r <= res_idx_nxt;
    res_val_r <= res_val_nxt;
    res_scr_r <= res_scr_nxt;
    res_row_r <= res_row_nxt;
    res_col_r <= res_col_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_cell_index_res = res_idx_r;
  assign out_cell_value     = res_val_r;
  assign out_scrolled       = res_scr_r;
  assign out_cursor_row     = res_row_r;
  assign out_cursor_column  = res_col_r;

`ifndef SYNTHESIS
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_scr_r |->
      res_row_r == 5'(tmcw_pkg::ROWS - 1) && res_col_r == '0)
    else $error("scrolled result with cursor off the bottom row start");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> mem_waddr < tmcw_pkg::IDX_W'(tmcw_pkg::CELLS))
    else $error("cell store write beyond the screen");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> !out_valid_r || out_ready)
    else $error("input taken while a result is held");

  a_scroll_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCROLL && cnt_r == tmcw_pkg::CNT_W'(tmcw_pkg::CELLS) |=>
      out_valid_r && state_r == ST_IDLE)
    else $error("scroll end did not present its result");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    info.row < 5'(tmcw_pkg::ROWS) && info.col < 7'(tmcw_pkg::COLUMNS))
    else $error("cursor outside the screen");
`endif

endmodule
